[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spc assertion failed");

// next-cycle implication
`define SPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spc assertion failed");

`endif

[rtl/spc_pkg.sv]
// Package for the segment plane clipper: register map, stage map and
// the record carried down the pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spc_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_NORMAL_X = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z = 3'd2;
  localparam logic [2:0] REG_POINT_X  = 3'd3;
  localparam logic [2:0] REG_POINT_Y  = 3'd4;
  localparam logic [2:0] REG_POINT_Z  = 3'd5;

  localparam logic [31:0] NORMAL_Z_RST = 32'h0001_0000;

  localparam int STG_DIFF  = 0;
  localparam int STG_MUL   = 1;
  localparam int STG_SUM   = 2;
  localparam int STG_SEL   = 3;
  localparam int STG_PP    = 4;
  localparam int STG_ACC   = 5;
  localparam int STG_DIV0  = 6;
  localparam int DIV_STEPS = 33;
  localparam int STG_OUT   = STG_DIV0 + DIV_STEPS;
  localparam int STAGES    = STG_OUT + 1;

  typedef struct packed {
    logic [2:0][31:0] s;
    logic [2:0][31:0] e;
    logic [2:0][32:0] ps;
    logic [2:0][32:0] pe;
    logic [2:0][64:0] prs;
    logic [2:0][64:0] pre;
    logic [66:0]      ds;
    logic [66:0]      de;
    logic             sin;
    logic             ein;
    logic [2:0][31:0] a;
    logic [2:0]       dneg;
    logic [2:0][32:0] dmag;
    logic [65:0]      da;
    logic [66:0]      den;
    logic [2:0][65:0] plo;
    logic [2:0][65:0] phi;
    logic [2:0][66:0] rem;
    logic [2:0][32:0] nlo;
    logic [2:0][32:0] q;
    logic [2:0][31:0] ks;
    logic [2:0][31:0] ke;
  } rec_t;

endpackage
`default_nettype wire

[rtl/spc_ifs.sv]
// Stream interfaces of the segment plane clipper: segment in, clipped
// segment out. Valid/ready handshake, no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface spc_seg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface spc_seg_out_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [31:0] kept_start_x;
  logic signed [31:0] kept_start_y;
  logic signed [31:0] kept_start_z;
  logic signed [31:0] kept_end_x;
  logic signed [31:0] kept_end_y;
  logic signed [31:0] kept_end_z;
  modport source (output valid, visible, kept_start_x, kept_start_y, kept_start_z,
                  kept_end_x, kept_end_y, kept_end_z, input ready);
  modport sink (input valid, visible, kept_start_x, kept_start_y, kept_start_z,
                kept_end_x, kept_end_y, kept_end_z, output ready);
endinterface
`default_nettype wire

[rtl/segment_plane_clipper.sv]
// Segment plane clipper top level: APB register file and 40-stage clip pipeline.
// Depends on spc_pkg, spc_ifs.sv and assert_macros.svh.
//
// Usage
//  - in_seg carries one segment per transaction (start and end point, Q16.16).
//  - out_seg returns one clipped segment per transaction, in order: visible,
//    kept start point and kept end point. Not visible gives all-zero points.
//  - Plane normal and point sit in six APB registers at 4*i, to be written
//    only while the pipeline is empty, not enforced here. pready is tied high.
//  - 40 register stages. One transaction per cycle is sustained while out_seg
//    is ready; the depth is set by the 33-step restoring divider (one
//    quotient bit per stage) that forms the intersection, plus six stages of
//    difference, multiply, sum, select, partial products and accumulate, and
//    the output register.
//  - Each stage holds while its successor is full and stalled, so a stalled
//    receiver fills the pipeline's bubbles first; in_seg.ready drops only
//    once every stage holds a transaction.
//  - Synchronous active-low reset clears all valid bits and loads the
//    register reset values (normal = +z, point = origin).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module segment_plane_clipper (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  spc_seg_in_if.sink                    in_seg,
  spc_seg_out_if.source                 out_seg,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [spc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [spc_pkg::DATA_W-1:0] pwdata,
  output logic      [spc_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);
  import spc_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [2:0][31:0] nrm_r;   // plane normal x,y,z
  logic [2:0][31:0] pnt_r;   // point on plane x,y,z
  logic [2:0]       reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r <= {NORMAL_Z_RST, 32'h0, 32'h0};
      pnt_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NORMAL_X: nrm_r[0] <= pwdata;
        REG_NORMAL_Y: nrm_r[1] <= pwdata;
        REG_NORMAL_Z: nrm_r[2] <= pwdata;
        REG_POINT_X:  pnt_r[0] <= pwdata;
        REG_POINT_Y:  pnt_r[1] <= pwdata;
        REG_POINT_Z:  pnt_r[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NORMAL_X: prdata = nrm_r[0];
      REG_NORMAL_Y: prdata = nrm_r[1];
      REG_NORMAL_Z: prdata = nrm_r[2];
      REG_POINT_X:  prdata = pnt_r[0];
      REG_POINT_Y:  prdata = pnt_r[1];
      REG_POINT_Z:  prdata = pnt_r[2];
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline
  rec_t             st_r   [STAGES];
  rec_t             st_nxt [STAGES];
  rec_t             src    [STAGES];
  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_src;
  logic [STAGES-1:0] rdy;

  always_comb begin
    src[0]   = '0;
    src[0].s = {in_seg.start_z, in_seg.start_y, in_seg.start_x};
    src[0].e = {in_seg.end_z, in_seg.end_y, in_seg.end_x};
  end
  assign v_src[0] = in_seg.valid;
  assign in_seg.ready = rdy[0];

  genvar g;
  generate
    for (g = 0; g < STAGES; g++) begin : g_stg
      if (g > 0) begin : g_link
        assign src[g]   = st_r[g-1];
        assign v_src[g] = v_r[g-1];
      end
      // a stage moves when empty or when its successor moves
      if (g == STAGES - 1) begin : g_rdy_last
        assign rdy[g] = !v_r[g] || out_seg.ready;
      end else begin : g_rdy
        assign rdy[g] = !v_r[g] || rdy[g+1];
      end

      if (g == STG_DIFF) begin : g_diff
        // endpoint minus plane point, 33-bit
        always_comb begin
          st_nxt[g] = src[g];
          for (int i = 0; i < 3; i++) begin
            st_nxt[g].ps[i] = {src[g].s[i][31], src[g].s[i]} - {pnt_r[i][31], pnt_r[i]};
            st_nxt[g].pe[i] = {src[g].e[i][31], src[g].e[i]} - {pnt_r[i][31], pnt_r[i]};
          end
        end
      end else if (g == STG_MUL) begin : g_mul
        always_comb begin
          st_nxt[g] = src[g];
          for (int i = 0; i < 3; i++) begin
            st_nxt[g].prs[i] = 65'($signed(nrm_r[i]) * $signed(src[g].ps[i]));
            st_nxt[g].pre[i] = 65'($signed(nrm_r[i]) * $signed(src[g].pe[i]));
          end
        end
      end else if (g == STG_SUM) begin : g_sum
        logic signed [66:0] ds_c, de_c;
        always_comb begin
          ds_c = $signed(src[g].prs[0]) + $signed(src[g].prs[1])
               + $signed(src[g].prs[2]);
          de_c = $signed(src[g].pre[0]) + $signed(src[g].pre[1])
               + $signed(src[g].pre[2]);
          st_nxt[g]     = src[g];
          st_nxt[g].ds  = ds_c;
          st_nxt[g].de  = de_c;
          st_nxt[g].sin = !ds_c[66];
          st_nxt[g].ein = !de_c[66];
        end
      end else if (g == STG_SEL) begin : g_sel
        // a = inside point, b = other; den = d(a) - d(b) > 0 when exactly one inside
        logic [66:0] da_c, db_c;
        logic [32:0] df;
        always_comb begin
          st_nxt[g] = src[g];
          da_c = src[g].sin ? src[g].ds : src[g].de;
          db_c = src[g].sin ? src[g].de : src[g].ds;
          st_nxt[g].da  = da_c[65:0];
          st_nxt[g].den = da_c - db_c;
          df = '0;
          for (int i = 0; i < 3; i++) begin
            st_nxt[g].a[i] = src[g].sin ? src[g].s[i] : src[g].e[i];
            if (src[g].sin)
              df = {src[g].e[i][31], src[g].e[i]} - {src[g].s[i][31], src[g].s[i]};
            else
              df = {src[g].s[i][31], src[g].s[i]} - {src[g].e[i][31], src[g].e[i]};
            st_nxt[g].dneg[i] = df[32];
            st_nxt[g].dmag[i] = df[32] ? (~df + 33'd1) : df;
          end
        end
      end else if (g == STG_PP) begin : g_pp
        // |b-a| * d(a), split into two 33x33 partial products
        always_comb begin
          st_nxt[g] = src[g];
          for (int i = 0; i < 3; i++) begin
            st_nxt[g].plo[i] = 66'(src[g].dmag[i] * src[g].da[32:0]);
            st_nxt[g].phi[i] = 66'(src[g].dmag[i] * src[g].da[65:33]);
          end
        end
      end else if (g == STG_ACC) begin : g_acc
        logic [98:0] num;
        always_comb begin
          st_nxt[g] = src[g];
          num = '0;
          for (int i = 0; i < 3; i++) begin
            num = {33'd0, src[g].plo[i]} + {src[g].phi[i], 33'd0};
            st_nxt[g].rem[i] = {1'b0, num[98:33]};
            st_nxt[g].nlo[i] = num[32:0];
            st_nxt[g].q[i]   = '0;
          end
        end
      end else if (g < STG_OUT) begin : g_div
        // one restoring quotient bit per stage
        logic [67:0] t;
        logic [67:0] dif;
        always_comb begin
          st_nxt[g] = src[g];
          t = '0;
          dif = '0;
          for (int i = 0; i < 3; i++) begin
            t   = {src[g].rem[i], src[g].nlo[i][32]};
            dif = t - {1'b0, src[g].den};
            st_nxt[g].rem[i] = dif[67] ? t[66:0] : dif[66:0];
            st_nxt[g].nlo[i] = {src[g].nlo[i][31:0], 1'b0};
            st_nxt[g].q[i]   = {src[g].q[i][31:0], !dif[67]};
          end
        end
      end else begin : g_out
        // a +/- delta, saturated; pass-through or zero for the trivial cases
        logic signed [34:0] r;
        always_comb begin
          st_nxt[g] = src[g];
          r = '0;
          for (int i = 0; i < 3; i++) begin
            if (src[g].dneg[i])
              r = {{3{src[g].a[i][31]}}, src[g].a[i]} - {2'b00, src[g].q[i]};
            else
              r = {{3{src[g].a[i][31]}}, src[g].a[i]} + {2'b00, src[g].q[i]};
            if (!src[g].sin && !src[g].ein) begin
              st_nxt[g].ks[i] = '0;
              st_nxt[g].ke[i] = '0;
            end else if (src[g].sin && src[g].ein) begin
              st_nxt[g].ks[i] = src[g].s[i];
              st_nxt[g].ke[i] = src[g].e[i];
            end else begin
              st_nxt[g].ks[i] = src[g].a[i];
              if (r > 35'sd2147483647)
                st_nxt[g].ke[i] = 32'h7FFF_FFFF;
              else if (r < -35'sd2147483648)
                st_nxt[g].ke[i] = 32'h8000_0000;
              else
                st_nxt[g].ke[i] = r[31:0];
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[g] <= 1'b0;
        end else if (rdy[g]) begin
          v_r[g] <= v_src[g];
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[g]) begin
          st_r[g] <= st_nxt[g];
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------- output
  assign out_seg.valid        = v_r[STAGES-1];
  assign out_seg.visible      = st_r[STAGES-1].sin || st_r[STAGES-1].ein;
  assign out_seg.kept_start_x = st_r[STAGES-1].ks[0];
  assign out_seg.kept_start_y = st_r[STAGES-1].ks[1];
  assign out_seg.kept_start_z = st_r[STAGES-1].ks[2];
  assign out_seg.kept_end_x   = st_r[STAGES-1].ke[0];
  assign out_seg.kept_end_y   = st_r[STAGES-1].ke[1];
  assign out_seg.kept_end_z   = st_r[STAGES-1].ke[2];

  // ---------------------------------------------------------------- checks
  `SPC_ASSERT_IMP(a_hidden_zero, out_seg.valid && !out_seg.visible, (st_r[STAGES-1].ks == '0))
  `SPC_ASSERT_NXT(a_accept_lands, in_seg.valid && in_seg.ready, v_r[0])
  `SPC_ASSERT_IMP(a_stall_holds_in, v_r[STAGES-1] && !out_seg.ready && (&v_r), !in_seg.ready)

endmodule
`default_nettype wire
